// File: rtl/cma_pkg.sv
// Package for the centered moving average block: sizes, widths and helpers.
// Used by rtl/centered_moving_average.sv. Depends on nothing else.
package cma_pkg;

  // Depth of the sample ring; the effective window never exceeds it.
  localparam int MAX_WIN = 31;

  // Fixed field widths.
  localparam int SMP_W = 16;
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(11);

  // Derived widths.
  localparam int PTR_W  = $clog2(MAX_WIN);
  localparam int K_W    = $clog2(MAX_WIN + 1);
  localparam int SUM_W  = SMP_W + K_W;
  localparam int REM_W  = K_W + 2;
  localparam int DCNT_W = $clog2(SUM_W + 1);

  // Largest odd window that fits in the ring.
  localparam int WIN_CAP = (MAX_WIN % 2 == 0) ? MAX_WIN - 1 : MAX_WIN;

  // An even window is raised by one, then clipped to the largest odd size.
  function automatic logic [K_W-1:0] eff_window(input logic [CFG_W-1:0] cfg);
    logic [CFG_W:0] w;
    w = {1'b0, cfg} | (CFG_W+1)'(1);
    if (w > (CFG_W+1)'(WIN_CAP)) begin
      w = (CFG_W+1)'(WIN_CAP);
    end
    return K_W'(w);
  endfunction

  // Ring pointer steps with wrap.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(MAX_WIN - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(MAX_WIN - 1) : p - PTR_W'(1);
  endfunction

endpackage

// File: rtl/centered_moving_average.sv
// Centered moving average with edge clipping; depends on rtl/cma_pkg.sv. Synchronous reset
// restores window_size 11 and clears the write pointer, the sample count and out_valid; the ring
// is not cleared. A pass-through result is registered and valid in the cycle after its
// transaction, one per cycle while the output is not stalled. Any other result sums k
// samples through the ring's single read port, runs the divider and is then loaded into the
// output register. The input stalls until the last result of a transaction is loaded.
module centered_moving_average
  import cma_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] sample,
  input  logic                    final_req,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SMP_W-1:0] average,
  output logic                    last_out
);

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_DIV, S_DONE} state_t;

  state_t                  state;
  logic [CFG_W-1:0]        win_cfg;
  logic [PTR_W-1:0]        wp;
  logic [K_W-1:0]          seen;
  logic [K_W-1:0]          flush_d;
  logic                    fin_seq;
  logic [K_W-1:0]          k_cur;
  logic [PTR_W-1:0]        rd_ptr;
  logic [K_W-1:0]          rd_cnt;
  logic                    rd_vld;
  logic signed [SUM_W-1:0] total;
  logic [SUM_W-1:0]        num;
  logic [REM_W-1:0]        rem;
  logic [DCNT_W-1:0]       div_cnt;
  logic                    neg;

  logic [SMP_W-1:0]        ring [MAX_WIN];
  logic [SMP_W-1:0]        ring_q;

  logic                    in_fire;
  logic                    out_free;
  logic                    out_load;
  logic                    pass_mode;
  logic [K_W-1:0]          win_eff;
  logic [K_W-1:0]          half;
  logic [K_W-1:0]          seen_inc;
  logic [K_W-1:0]          d_first;
  logic [K_W:0]            k_fin_full;
  logic [K_W-1:0]          k_fin;
  logic [K_W-1:0]          k_run;
  logic [K_W:0]            k_next_full;
  logic [K_W-1:0]          k_next;
  logic [REM_W-1:0]        rem_sh;
  logic [REM_W-1:0]        den;
  logic                    ge;
  logic [SUM_W-1:0]        tot_abs;
  logic [SUM_W-1:0]        num_init;
  logic [SMP_W-1:0]        avg_res;

  // Handshake and window decode.
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign pass_mode = (win_cfg <= CFG_W'(1));
  assign win_eff   = eff_window(win_cfg);
  assign half      = win_eff >> 1;
  assign in_stall  = (state != S_IDLE) || (pass_mode && !out_free);

  // A new result enters the output register in these two cases.
  assign out_load = ((state == S_IDLE) && in_fire && pass_mode) ||
                    ((state == S_DONE) && out_free);

  // Window counts for the first result of a transaction.
  assign seen_inc    = (seen == K_W'(MAX_WIN)) ? seen : seen + K_W'(1);
  assign d_first     = (half < seen_inc) ? half : seen_inc - K_W'(1);
  assign k_fin_full  = {1'b0, half} + {1'b0, d_first} + (K_W+1)'(1);
  assign k_fin       = (k_fin_full < {1'b0, seen_inc}) ? K_W'(k_fin_full) : seen_inc;
  assign k_run       = (seen_inc < win_eff) ? seen_inc : win_eff;

  // Window count for the next result of a flush.
  assign k_next_full = {1'b0, half} + {1'b0, flush_d};
  assign k_next      = (k_next_full < {1'b0, seen}) ? K_W'(k_next_full) : seen;

  // Divider step: numerator is 2|sum| + k, divisor is 2k.
  assign den      = {1'b0, k_cur, 1'b0};
  assign rem_sh   = {rem[REM_W-2:0], num[SUM_W-1]};
  assign ge       = (rem_sh >= den);
  assign tot_abs  = total[SUM_W-1] ? SUM_W'(-total) : SUM_W'(total);
  assign num_init = {tot_abs[SUM_W-2:0], 1'b0} + SUM_W'(k_cur);
  assign avg_res  = neg ? (SMP_W'(0) - num[SMP_W-1:0]) : num[SMP_W-1:0];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_cfg <= CFG_RESET;
    end else if (cfg_we) begin
      win_cfg <= cfg_wdata;
    end
  end

  // Sample ring: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (in_fire && !pass_mode) begin
      ring[wp] <= sample;
    end
    ring_q <= ring[rd_ptr];
  end

  // Sequencer: accept, sum the recent samples, divide, hand the result off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      seen      <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Output register: take a new result, or drop one that was handed off.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (pass_mode) begin
              average   <= sample;
              last_out  <= final_req;
              if (final_req) begin
                seen <= '0;
              end
            end else begin
              wp      <= ptr_inc(wp);
              seen    <= seen_inc;
              fin_seq <= final_req;
              rd_ptr  <= wp;
              rd_cnt  <= '0;
              rd_vld  <= 1'b0;
              total   <= '0;
              if (final_req) begin
                flush_d <= d_first;
                k_cur   <= k_fin;
                state   <= S_SUM;
              end else if (seen_inc > half) begin
                flush_d <= '0;
                k_cur   <= k_run;
                state   <= S_SUM;
              end
            end
          end
        end
        S_SUM: begin
          // Issue one read a cycle, newest sample first, and add what returns.
          rd_vld <= (rd_cnt != k_cur);
          if (rd_cnt != k_cur) begin
            rd_ptr <= ptr_dec(rd_ptr);
            rd_cnt <= rd_cnt + K_W'(1);
          end
          if (rd_vld) begin
            total <= total + {{K_W{ring_q[SMP_W-1]}}, ring_q};
          end
          if (rd_cnt == k_cur && !rd_vld) begin
            num     <= num_init;
            neg     <= total[SUM_W-1];
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= ge ? (rem_sh - den) : rem_sh;
          num     <= {num[SUM_W-2:0], ge};
          div_cnt <= div_cnt + DCNT_W'(1);
          if (div_cnt == DCNT_W'(SUM_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            average   <= avg_res;
            last_out  <= fin_seq && (flush_d == '0);
            if (flush_d != '0) begin
              // Next result of the flush, over a window that is no wider.
              flush_d <= flush_d - K_W'(1);
              k_cur   <= k_next;
              rd_ptr  <= ptr_dec(wp);
              rd_cnt  <= '0;
              rd_vld  <= 1'b0;
              total   <= '0;
              state   <= S_SUM;
            end else begin
              if (fin_seq) begin
                seen <= '0;
              end
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The sample count saturates at the ring depth.
  a_seen_range: assert property (@(posedge clk) disable iff (rst)
    seen <= K_W'(MAX_WIN))
    else $error("sample count beyond ring depth");

  // The write pointer stays inside the ring.
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp < PTR_W'(MAX_WIN))
    else $error("write pointer outside ring");

  // A sum never reads more samples than have been stored.
  a_sum_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |-> (rd_cnt <= k_cur) && (k_cur <= seen) && (k_cur != '0))
    else $error("sum reads beyond stored samples");

  // A transaction is only taken while the sequencer is idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !pass_mode) |=> (state == S_IDLE) || (state == S_SUM))
    else $error("sequencer left idle on an unexpected path");

endmodule

// File: bench/centered_moving_average_test.sv
// Self-checking bench for the centered moving average block: sends sample sequences
// under many window settings and checks every average against an in-bench predictor.
// Depends on rtl/cma_pkg.sv and rtl/centered_moving_average.sv.
module centered_moving_average_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cma_pkg::*;

  // Run shape: total samples, quiet cycles after the last result, and sample extremes.
  localparam int TOTAL_ITEMS = 270;
  localparam int DRAIN_SLACK = 64;
  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7fff;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  typedef struct {
    logic signed [SMP_W-1:0] average;
    logic                    last;
  } avg_result_t;

  // Block inputs start at known values before the first clock edge.
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [SMP_W-1:0] sample = '0;
  logic                    final_req = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SMP_W-1:0] average;
  logic                    last_out;

  // Predictor state: window register, sample history ring and sequence fill count.
  logic [CFG_W-1:0]        win_cfg = CFG_RESET;
  logic signed [SMP_W-1:0] hist_ring [MAX_WIN];
  int                      hist_ptr = 0;
  int                      hist_count = 0;
  avg_result_t             expected_averages [$];

  logic [CFG_W-1:0] extreme_windows [5] = '{5'd0, 5'd1, 5'd2, 5'd30, 5'd31};

  bit          calm = 1'b0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          sequences = 0;
  int          errors = 0;
  int unsigned stall_run = 0;

  centered_moving_average dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .final_req (final_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average),
    .last_out  (last_out)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string field, input int want, input int got);
    errors++;
    $display("%0t ns: result %0d mismatch on %s: expected %0d, got %0d",
             $realtime, results_checked, field, want, got);
  endtask

  // Mean of a sum over k samples, rounded to nearest with ties away from zero.
  function automatic logic signed [SMP_W-1:0] rounded_mean(input int total, input int k);
    int mag;
    int q;
    mag = (total < 0) ? -total : total;
    q = (2 * mag + k) / (2 * k);
    return SMP_W'((total < 0) ? -q : q);
  endfunction

  // Sum of the k most recently stored samples.
  function automatic int recent_total(input int k);
    int total;
    int idx;
    total = 0;
    for (int a = 0; a < k; a++) begin
      idx = (hist_ptr + MAX_WIN - 1 - a) % MAX_WIN;
      total += hist_ring[idx];
    end
    return total;
  endfunction

  // Appends one average to the tail of the expected queue.
  function automatic void queue_average(input avg_result_t res);
    expected_averages = {expected_averages, res};
  endfunction

  // Works out the averages one accepted sample causes and queues them in order.
  function automatic void predict_averages(input logic signed [SMP_W-1:0] value,
                                           input logic is_last);
    avg_result_t res;
    int win;
    int half;
    int k;
    int d;
    // Pass-through: the sample comes back as is and nothing is stored.
    if (win_cfg <= 1) begin
      res.average = value;
      res.last = is_last;
      queue_average(res);
      if (is_last) hist_count = 0;
      return;
    end
    win = int'(win_cfg) | 1;
    half = win / 2;
    hist_ring[hist_ptr] = value;
    hist_ptr = (hist_ptr == MAX_WIN - 1) ? 0 : hist_ptr + 1;
    if (hist_count < MAX_WIN) hist_count++;
    // Mid-sequence: one centered output once half a window lies ahead of it.
    if (!is_last) begin
      if (hist_count > half) begin
        k = (hist_count < win) ? hist_count : win;
        res.average = rounded_mean(recent_total(k), k);
        res.last = 1'b0;
        queue_average(res);
      end
      return;
    end
    // Final sample: flush every pending output over a window clipped at the tail.
    d = (half < hist_count - 1) ? half : hist_count - 1;
    for (; d >= 0; d--) begin
      k = half + 1 + d;
      if (k > hist_count) k = hist_count;
      res.average = rounded_mean(recent_total(k), k);
      res.last = (d == 0);
      queue_average(res);
    end
    hist_count = 0;
  endfunction

  // Sends one sample transaction, with an occasional gap before it.
  task automatic send_sample(input logic signed [SMP_W-1:0] value, input logic is_last);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    final_req <= is_last;
    do @(posedge clk); while (in_stall);
    predict_averages(value, is_last);
    items_sent++;
  endtask

  // Drops valid and holds off until every queued average has arrived and the block is idle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_averages.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  // Writes the window register once the block is idle.
  task automatic set_window(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    win_cfg = value;
  endtask

  function automatic logic signed [SMP_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      3: return -16'sd1;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Output side: random stall bursts, none while the bench is calm.
  always @(negedge clk) begin
    if (stall_run == 0 && !calm && $urandom_range(0, 4) == 0) stall_run = $urandom_range(1, 6);
    out_stall <= (stall_run != 0);
    if (stall_run != 0) stall_run--;
  end

  // Compares each accepted result with the oldest queued average.
  always @(posedge clk) begin
    avg_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_averages.size() == 0) begin
        report_mismatch("unexpected result", 0, average);
      end else begin
        want = expected_averages.pop_front();
        if (average !== want.average) report_mismatch("average", want.average, average);
        if (last_out !== want.last) report_mismatch("last_out", want.last, last_out);
        results_checked++;
      end
    end
  end

  // Reset window of 11 with a sequence shorter than half a window.
  task automatic test_reset_window_short();
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b0);
    send_sample(16'sd100, 1'b1);
  endtask

  // Both pass-through settings, with the final flag passed along.
  task automatic test_pass_through();
    set_window(5'd0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(SMP_MIN, 1'b1);
    set_window(5'd1);
    send_sample(-16'sd1, 1'b0);
    send_sample('0, 1'b1);
  endtask

  // Even window raised to three; clipped edges give even divisors and exact ties.
  task automatic test_rounding_ties();
    set_window(5'd2);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd4, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b1);
  endtask

  // Widest window with alternating extremes; the whole sequence is flushed at the end.
  task automatic test_full_window();
    set_window(5'd30);
    for (int i = 0; i < 6; i++) send_sample((i % 2) ? SMP_MIN : SMP_MAX, i == 5);
  endtask

  // A sequence of one sample.
  task automatic test_single_sample();
    set_window(5'd5);
    send_sample(-16'sd12345, 1'b1);
  endtask

  // Window shrinks partway through a sequence that has not yet produced anything.
  task automatic test_window_change_mid_sequence();
    set_window(5'd7);
    send_sample(16'sd10, 1'b0);
    send_sample(16'sd20, 1'b0);
    send_sample(16'sd30, 1'b0);
    set_window(5'd3);
    send_sample(16'sd40, 1'b0);
    send_sample(16'sd50, 1'b1);
  endtask

  // Random sequences over random and extreme windows, some with a window change inside.
  task automatic test_random_sequences();
    int len;
    int change_at;
    logic [CFG_W-1:0] w;
    while (items_sent < TOTAL_ITEMS) begin
      w = ($urandom_range(0, 2) == 0) ? extreme_windows[$urandom_range(0, 4)]
                                      : CFG_W'($urandom_range(0, 31));
      set_window(w);
      calm = (sequences % 4 == 3) || (items_sent > TOTAL_ITEMS - 40);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      change_at = (len > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1) : 0;
      for (int i = 0; i < len; i++) begin
        if (i != 0 && i == change_at) set_window(CFG_W'($urandom_range(0, 31)));
        send_sample(random_sample(), i == len - 1);
      end
      sequences++;
    end
  endtask

  // Test sequence.
  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    test_reset_window_short();
    test_pass_through();
    test_rounding_ties();
    test_full_window();
    test_single_sample();
    test_window_change_mid_sequence();
    test_random_sequences();
    calm = 1'b1;
    wait_drained();
    $display("Sent %0d samples in %0d random sequences plus directed ones; %0d averages",
             items_sent, sequences, results_checked);
    $display("checked across pass-through, even, odd and full-width windows.");
    if (errors == 0) begin
      $display("centered_moving_average_test: done, clean");
    end else begin
      $display("centered_moving_average_test: done, errors");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #4_000_000;
    $display("centered_moving_average_test: done, errors");
    $finish;
  end

endmodule
